>>> src/fads_pkg.sv
`default_nettype none

package fads_pkg;

    // detector lines wired to the panel
    localparam int unsigned LINE_COUNT = 8;

    // field widths
    localparam int unsigned OP_W   = 3;
    localparam int unsigned LINE_W = 3;
    localparam int unsigned SEC_W  = 9;
    localparam int unsigned CFG_W  = 9;

    // timing constants
    localparam int unsigned MS_PER_S    = 1000;
    localparam int unsigned BLINK_MS    = 500;
    localparam int unsigned ELAPSED_MAX = 524287;
    localparam int unsigned SAT_S       = ELAPSED_MAX / MS_PER_S;
    localparam int unsigned SAT_MS      = ELAPSED_MAX % MS_PER_S;
    localparam int unsigned ES_W        = $clog2(SAT_S + 1);
    localparam int unsigned MS_W        = $clog2(MS_PER_S);
    localparam int unsigned BLINK_W     = 9;

    // register reset values
    localparam logic [CFG_W-1:0] PREALARM_RST = 9'd30;
    localparam logic [CFG_W-1:0] VERIFY_RST   = 9'd60;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_MENU   = 3'd1,
        MODE_PRE    = 3'd2,
        MODE_VERIFY = 3'd3,
        MODE_FIRE   = 3'd4
    } t_mode;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_DETECT     = 3'd1,
        OP_ACK        = 3'd2,
        OP_RESET      = 3'd3,
        OP_MENU_ENTER = 3'd4,
        OP_MENU_EXIT  = 3'd5
    } t_opcode;

    typedef enum logic [0:0] {
        CFG_PREALARM = 1'b0,
        CFG_VERIFY   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [LINE_W-1:0] detector_line;
        logic              permitted;
    } t_event;

    typedef struct packed {
        logic [2:0]        alarm_mode;
        logic              led_on;
        logic              vent_on;
        logic              play_message;
        logic              stop_message;
        logic              clear_latches;
        logic [LINE_W-1:0] alarm_line;
        logic [SEC_W-1:0]  seconds_left;
    } t_result;

endpackage

`default_nettype wire

>>> src/fire_alarm_delay_sequencer_top.sv
// path: an item is held in the input register and passes the core when the result
//   register is free; its result is then registered there (one result per item)
// throughput: one item per cycle when not stalled, set by one state update per event
// reset: synchronous active low; mode idle, timers and led/vent cleared,
//   T1 = 30 s, T2 = 60 s, no result pending
`default_nettype none

module fire_alarm_delay_sequencer_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration write channel
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [0:0]                          i_cfg_index,
    input  wire [fads_pkg::CFG_W-1:0]          i_cfg_data,
    // event channel
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire [fads_pkg::OP_W-1:0]           i_opcode,
    input  wire [fads_pkg::LINE_W-1:0]         i_detector_line,
    input  wire                                i_permitted,
    // result channel
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic [2:0]                         o_alarm_mode,
    output logic                               o_led_on,
    output logic                               o_vent_on,
    output logic                               o_play_message,
    output logic                               o_stop_message,
    output logic                               o_clear_latches,
    output logic [fads_pkg::LINE_W-1:0]        o_alarm_line,
    output logic [fads_pkg::SEC_W-1:0]         o_seconds_left
);

    logic                r_in_valid;
    fads_pkg::t_event    r_in;
    logic                r_out_valid;
    fads_pkg::t_result   r_out;
    fads_pkg::t_result   result;
    logic                advance;
    logic                in_take;

    // event moves into the core when the result register is free
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.opcode        <= i_opcode;
            r_in.detector_line <= i_detector_line;
            r_in.permitted     <= i_permitted;
        end
    end

    fads_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (fads_pkg::t_cfg_idx'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .i_ev_valid  (advance),
        .i_ev        (r_in),
        .o_result    (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_alarm_mode    = r_out.alarm_mode;
    assign o_led_on        = r_out.led_on;
    assign o_vent_on       = r_out.vent_on;
    assign o_play_message  = r_out.play_message;
    assign o_stop_message  = r_out.stop_message;
    assign o_clear_latches = r_out.clear_latches;
    assign o_alarm_line    = r_out.alarm_line;
    assign o_seconds_left  = r_out.seconds_left;

endmodule

`default_nettype wire

>>> src/fads_core.sv
`default_nettype none

module fads_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire fads_pkg::t_cfg_idx            i_cfg_index,
    input  wire [fads_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire                                i_ev_valid,
    input  wire fads_pkg::t_event              i_ev,
    output fads_pkg::t_result                  o_result
);

    localparam logic [fads_pkg::MS_W-1:0]    MS_LAST   = fads_pkg::MS_W'(fads_pkg::MS_PER_S - 1);
    localparam logic [fads_pkg::ES_W-1:0]    SAT_S_V   = fads_pkg::ES_W'(fads_pkg::SAT_S);
    localparam logic [fads_pkg::MS_W-1:0]    SAT_MS_V  = fads_pkg::MS_W'(fads_pkg::SAT_MS);
    localparam logic [fads_pkg::BLINK_W-1:0] BLINK_V   = fads_pkg::BLINK_W'(fads_pkg::BLINK_MS);
    localparam logic [fads_pkg::BLINK_W-1:0] BLINK_TOP = '1;

    // configuration registers
    logic [fads_pkg::CFG_W-1:0] r_prealarm_s;
    logic [fads_pkg::CFG_W-1:0] r_verify_s;

    // sequencer state
    fads_pkg::t_mode                 r_mode, n_mode;
    logic [fads_pkg::ES_W-1:0]       r_elapsed_s, n_elapsed_s;
    logic [fads_pkg::MS_W-1:0]       r_elapsed_ms, n_elapsed_ms;
    logic [fads_pkg::BLINK_W-1:0]    r_blink, n_blink;
    logic                            r_led, n_led;
    logic                            r_vent, n_vent;
    logic [fads_pkg::LINE_W-1:0]     r_line, n_line;

    logic                            play, stop, clr;
    logic [fads_pkg::CFG_W-1:0]      stage_s;
    logic [fads_pkg::CFG_W-1:0]      next_stage_s;
    logic [fads_pkg::ES_W-1:0]       left_full;
    logic [fads_pkg::SEC_W-1:0]      left;
    logic                            line_ok;

    assign line_ok = 32'(i_ev.detector_line) < fads_pkg::LINE_COUNT;
    assign stage_s = (r_mode == fads_pkg::MODE_PRE) ? r_prealarm_s : r_verify_s;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prealarm_s <= fads_pkg::PREALARM_RST;
            r_verify_s   <= fads_pkg::VERIFY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fads_pkg::CFG_PREALARM: r_prealarm_s <= i_cfg_data;
                fads_pkg::CFG_VERIFY:   r_verify_s   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= fads_pkg::MODE_IDLE;
            r_elapsed_s  <= '0;
            r_elapsed_ms <= '0;
            r_blink      <= '0;
            r_led        <= 1'b0;
            r_vent       <= 1'b0;
            r_line       <= '0;
        end else if (i_ev_valid) begin
            r_mode       <= n_mode;
            r_elapsed_s  <= n_elapsed_s;
            r_elapsed_ms <= n_elapsed_ms;
            r_blink      <= n_blink;
            r_led        <= n_led;
            r_vent       <= n_vent;
            r_line       <= n_line;
        end
    end

    // next state for one event
    always_comb begin
        n_mode       = r_mode;
        n_elapsed_s  = r_elapsed_s;
        n_elapsed_ms = r_elapsed_ms;
        n_blink      = r_blink;
        n_led        = r_led;
        n_vent       = r_vent;
        n_line       = r_line;
        play         = 1'b0;
        stop         = 1'b0;
        clr          = 1'b0;
        case (i_ev.opcode)
            fads_pkg::OP_TICK: begin
                if (r_mode == fads_pkg::MODE_PRE || r_mode == fads_pkg::MODE_VERIFY) begin
                    // saturating elapsed time, kept as seconds plus milliseconds
                    if (!(r_elapsed_s == SAT_S_V && r_elapsed_ms == SAT_MS_V)) begin
                        if (r_elapsed_ms == MS_LAST) begin
                            n_elapsed_ms = '0;
                            n_elapsed_s  = r_elapsed_s + 1'b1;
                        end else begin
                            n_elapsed_ms = r_elapsed_ms + 1'b1;
                        end
                    end
                    if (r_mode == fads_pkg::MODE_PRE) begin
                        // led blink
                        if (r_blink != BLINK_TOP) begin
                            n_blink = r_blink + 1'b1;
                        end
                        if (n_blink > BLINK_V) begin
                            n_blink = '0;
                            n_led   = ~r_led;
                        end
                    end else begin
                        n_led = 1'b1;
                    end
                    // stage timeout
                    if (n_elapsed_s > fads_pkg::ES_W'(stage_s) ||
                        (n_elapsed_s == fads_pkg::ES_W'(stage_s) && n_elapsed_ms != '0)) begin
                        n_mode = fads_pkg::MODE_FIRE;
                        n_vent = 1'b1;
                        n_led  = 1'b0;
                        play   = 1'b1;
                    end
                end
            end
            fads_pkg::OP_DETECT: begin
                if ((r_mode == fads_pkg::MODE_IDLE || r_mode == fads_pkg::MODE_MENU) && line_ok) begin
                    n_mode       = fads_pkg::MODE_PRE;
                    n_line       = i_ev.detector_line;
                    n_elapsed_s  = '0;
                    n_elapsed_ms = '0;
                    n_blink      = '0;
                    n_led        = 1'b0;
                end
            end
            fads_pkg::OP_ACK: begin
                if (i_ev.permitted && r_mode == fads_pkg::MODE_PRE) begin
                    n_mode       = fads_pkg::MODE_VERIFY;
                    n_elapsed_s  = '0;
                    n_elapsed_ms = '0;
                    n_led        = 1'b1;
                end
            end
            fads_pkg::OP_RESET: begin
                if (i_ev.permitted &&
                    (r_mode == fads_pkg::MODE_VERIFY || r_mode == fads_pkg::MODE_FIRE)) begin
                    n_mode       = fads_pkg::MODE_IDLE;
                    n_elapsed_s  = '0;
                    n_elapsed_ms = '0;
                    n_blink      = '0;
                    n_led        = 1'b0;
                    n_vent       = 1'b0;
                    stop         = 1'b1;
                    clr          = 1'b1;
                end
            end
            fads_pkg::OP_MENU_ENTER: begin
                if (i_ev.permitted && r_mode != fads_pkg::MODE_MENU) begin
                    n_mode = fads_pkg::MODE_MENU;
                end
            end
            fads_pkg::OP_MENU_EXIT: begin
                if (r_mode == fads_pkg::MODE_MENU) begin
                    n_mode = fads_pkg::MODE_IDLE;
                    n_led  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // whole seconds left of the running stage
    assign next_stage_s = (n_mode == fads_pkg::MODE_PRE) ? r_prealarm_s : r_verify_s;

    always_comb begin
        left_full = '0;
        if ((n_mode == fads_pkg::MODE_PRE || n_mode == fads_pkg::MODE_VERIFY) &&
            n_elapsed_s < fads_pkg::ES_W'(next_stage_s)) begin
            left_full = fads_pkg::ES_W'(next_stage_s) - n_elapsed_s
                        - fads_pkg::ES_W'(n_elapsed_ms != '0);
        end
    end

    assign left = left_full[fads_pkg::SEC_W-1:0];

    // result of this event
    always_comb begin
        o_result.alarm_mode    = n_mode;
        o_result.led_on        = n_led;
        o_result.vent_on       = n_vent;
        o_result.play_message  = play;
        o_result.stop_message  = stop;
        o_result.clear_latches = clr;
        o_result.alarm_line    = n_line;
        o_result.seconds_left  = left;
    end

    // millisecond part never reaches a full second
    a_ms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elapsed_ms <= MS_LAST)
        else $error("elapsed milliseconds out of range");

    // message start only with the move into fire alarm
    a_play_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ev_valid && o_result.play_message |=> r_mode == fads_pkg::MODE_FIRE && r_vent)
        else $error("message start without fire alarm");

    // a performed reset leaves everything off
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ev_valid && o_result.stop_message |=>
            r_mode == fads_pkg::MODE_IDLE && !r_led && !r_vent)
        else $error("reset did not return to idle");

    // verification always shows a lit led
    a_verify_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == fads_pkg::MODE_VERIFY |-> r_led)
        else $error("led dark in verification");

    // state moves only on an event
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ev_valid |=> $stable(r_mode) && $stable(r_elapsed_ms))
        else $error("state changed without an event");

endmodule

`default_nettype wire
